// ===== hdl/sdst_pkg.sv =====
package sdst_pkg;

   localparam int SECTOR_BYTES  = 512;
   localparam int R1_POLL_LIMIT = 10;
   localparam int BUF_AW        = $clog2(SECTOR_BYTES);
   localparam int COUNT_W       = BUF_AW + 1;
   localparam int POLL_W        = 16;
   localparam int CSR_DW        = 16;
   localparam int CSR_IW        = 2;

   localparam logic [7:0] CMD_READ_BLOCK  = 8'd17;
   localparam logic [7:0] CMD_WRITE_BLOCK = 8'd24;
   localparam logic [7:0] CMD_TAG         = 8'h40;
   localparam logic [7:0] R1_BUSY_MASK    = 8'h80;
   localparam logic [7:0] DATA_TOKEN      = 8'hFE;
   localparam logic [7:0] IDLE_BYTE       = 8'hFF;
   localparam logic [7:0] DRESP_MASK      = 8'h1F;
   localparam logic [7:0] DRESP_ACCEPTED  = 8'h05;
   localparam int         ADDR_SHIFT      = 9;
   localparam int         FRAME_BYTES     = 6;

   localparam logic [POLL_W-1:0] TOKEN_LIMIT_RESET = 16'd100;
   localparam logic [POLL_W-1:0] READY_LIMIT_RESET = 16'd250;

   typedef enum logic [CSR_IW-1:0] {
      CSR_BLOCK_ADDRESSING = 2'd0,
      CSR_TOKEN_POLL_LIMIT = 2'd1,
      CSR_READY_POLL_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FN_START_READ  = 2'd0,
      FN_START_WRITE = 2'd1,
      FN_EXCHANGE    = 2'd2,
      FN_LOAD        = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_SECTOR_ZERO   = 3'd1,
      ST_CMD_REJECTED  = 3'd2,
      ST_TOKEN_TIMEOUT = 3'd3,
      ST_NOT_READY     = 3'd4,
      ST_DRESP_ERROR   = 3'd5,
      ST_BUSY_TIMEOUT  = 3'd6
   } status_type;

   typedef enum logic [10:0] {
      PH_IDLE      = 11'b000_0000_0001,
      PH_PRE_READY = 11'b000_0000_0010,
      PH_GAP       = 11'b000_0000_0100,
      PH_FRAME     = 11'b000_0000_1000,
      PH_R1        = 11'b000_0001_0000,
      PH_TOKEN     = 11'b000_0010_0000,
      PH_RDATA     = 11'b000_0100_0000,
      PH_WTOKEN    = 11'b000_1000_0000,
      PH_WDATA     = 11'b001_0000_0000,
      PH_WRESP     = 11'b010_0000_0000,
      PH_BUSY      = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] mosi_byte;
      logic       select_active;
      logic [7:0] read_byte;
      logic       read_byte_valid;
      logic       done_res;
      status_type status;
   } result_type;

   typedef struct packed {
      result_type res;
      logic       buf_sel;
   } stage_type;

   function automatic logic [7:0] frame_byte(input logic [COUNT_W-1:0] k,
                                             input logic wr,
                                             input logic [31:0] addr);
      logic [7:0] b;
      begin
         case (k)
            COUNT_W'(0): b = (wr ? CMD_WRITE_BLOCK : CMD_READ_BLOCK) | CMD_TAG;
            COUNT_W'(1): b = addr[31:24];
            COUNT_W'(2): b = addr[23:16];
            COUNT_W'(3): b = addr[15:8];
            COUNT_W'(4): b = addr[7:0];
            default:     b = IDLE_BYTE;
         endcase
         return b;
      end
   endfunction

endpackage

// ===== hdl/sdst_ram.sv =====
module sdst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sd_spi_sector_transfer.sv =====
// Pipeline: a result is registered in stage p1, then in the output register.
// Throughput: one item per cycle while rsp_ready does not stall, set by the
// single write and read port of the 512-byte sector buffer RAM (at most one
// access per item). Load items produce no result. Reset: synchronous,
// active high; clears phase, counters and valids; limits return to defaults.
// The sector buffer is not cleared and holds unknown data until written.
module sd_spi_sector_transfer
   import sdst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [31:0]         req_sector,
   input  logic [7:0]          req_miso_byte,
   input  logic [BUF_AW-1:0]   req_buf_index,
   input  logic [7:0]          req_buf_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_mosi_byte,
   output logic                rsp_select_active,
   output logic [7:0]          rsp_read_byte,
   output logic                rsp_read_byte_valid,
   output logic                rsp_done_res,
   output logic [2:0]          rsp_status,
   input  logic                csr_we,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   logic                block_addressing_ff;
   logic [POLL_W-1:0]   token_poll_limit_ff;
   logic [POLL_W-1:0]   ready_poll_limit_ff;

   phase_type           phase_ff, phase_in;
   logic                op_is_write_ff, op_is_write_in;
   logic [31:0]         card_address_ff, card_address_in;
   logic [COUNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [POLL_W-1:0]   poll_count_ff, poll_count_in;

   logic                p1_valid_ff;
   stage_type           p1_ff, p1_in;
   logic                rsp_valid_ff;
   result_type          rsp_ff, rsp_in;

   logic                req_fire;
   logic                p1_adv;
   logic                out_free;
   logic                res_valid;
   logic [COUNT_W-1:0]  byte_inc;
   logic [POLL_W-1:0]   poll_inc;

   logic                ram_we;
   logic [BUF_AW-1:0]   ram_waddr;
   logic [7:0]          ram_wdata;
   logic                ram_re;
   logic [BUF_AW-1:0]   ram_raddr;
   logic [7:0]          ram_rd_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign p1_adv    = p1_valid_ff && out_free;
   assign req_ready = !p1_valid_ff || p1_adv;
   assign req_fire  = req_valid && req_ready;
   assign byte_inc  = byte_count_ff + COUNT_W'(1);
   assign poll_inc  = poll_count_ff + POLL_W'(1);

   always_comb begin
      phase_in        = phase_ff;
      op_is_write_in  = op_is_write_ff;
      card_address_in = card_address_ff;
      byte_count_in   = byte_count_ff;
      poll_count_in   = poll_count_ff;
      res_valid       = 1'b0;
      p1_in.buf_sel   = 1'b0;
      p1_in.res       = '{mosi_byte: IDLE_BYTE, select_active: 1'b1, read_byte: 8'h00,
                          read_byte_valid: 1'b0, done_res: 1'b0, status: ST_OK};
      ram_we          = 1'b0;
      ram_waddr       = req_buf_index;
      ram_wdata       = req_buf_data;
      ram_re          = 1'b0;
      ram_raddr       = '0;

      if (req_fire) begin
         case (req_func)
            FN_LOAD: begin
               ram_we = 1'b1;
            end
            FN_START_READ, FN_START_WRITE: begin
               res_valid = 1'b1;
               if (req_sector == 32'd0) begin
                  phase_in                  = PH_IDLE;
                  p1_in.res.select_active   = 1'b0;
                  p1_in.res.done_res        = 1'b1;
                  p1_in.res.status          = ST_SECTOR_ZERO;
               end else begin
                  op_is_write_in  = (req_func == FN_START_WRITE);
                  card_address_in = block_addressing_ff ? req_sector
                                                        : (req_sector << ADDR_SHIFT);
                  byte_count_in   = '0;
                  poll_count_in   = '0;
                  if (req_func == FN_START_WRITE) begin
                     phase_in = PH_PRE_READY;
                  end else begin
                     phase_in                = PH_GAP;
                     p1_in.res.select_active = 1'b0;
                  end
               end
            end
            FN_EXCHANGE: begin
               res_valid = 1'b1;
               case (phase_ff)
                  PH_PRE_READY: begin
                     if (req_miso_byte == IDLE_BYTE) begin
                        phase_in                = PH_GAP;
                        p1_in.res.select_active = 1'b0;
                     end else begin
                        poll_count_in = poll_inc;
                        if (poll_inc >= ready_poll_limit_ff) begin
                           phase_in                = PH_IDLE;
                           p1_in.res.select_active = 1'b0;
                           p1_in.res.done_res      = 1'b1;
                           p1_in.res.status        = ST_NOT_READY;
                        end
                     end
                  end
                  PH_GAP: begin
                     phase_in            = PH_FRAME;
                     byte_count_in       = '0;
                     p1_in.res.mosi_byte = frame_byte('0, op_is_write_ff, card_address_ff);
                  end
                  PH_FRAME: begin
                     byte_count_in = byte_inc;
                     if (byte_inc >= COUNT_W'(FRAME_BYTES)) begin
                        phase_in      = PH_R1;
                        poll_count_in = '0;
                     end else begin
                        p1_in.res.mosi_byte = frame_byte(byte_inc, op_is_write_ff,
                                                         card_address_ff);
                     end
                  end
                  PH_R1: begin
                     if ((req_miso_byte & R1_BUSY_MASK) == 8'h00) begin
                        if (req_miso_byte != 8'h00) begin
                           phase_in                = PH_IDLE;
                           p1_in.res.select_active = 1'b0;
                           p1_in.res.done_res      = 1'b1;
                           p1_in.res.status        = ST_CMD_REJECTED;
                        end else begin
                           poll_count_in = '0;
                           if (op_is_write_ff) begin
                              phase_in            = PH_WTOKEN;
                              p1_in.res.mosi_byte = DATA_TOKEN;
                           end else begin
                              phase_in = PH_TOKEN;
                           end
                        end
                     end else begin
                        poll_count_in = poll_inc;
                        if (poll_inc >= POLL_W'(R1_POLL_LIMIT)) begin
                           phase_in                = PH_IDLE;
                           p1_in.res.select_active = 1'b0;
                           p1_in.res.done_res      = 1'b1;
                           p1_in.res.status        = ST_CMD_REJECTED;
                        end
                     end
                  end
                  PH_TOKEN: begin
                     if (req_miso_byte == DATA_TOKEN) begin
                        phase_in      = PH_RDATA;
                        byte_count_in = '0;
                     end else begin
                        poll_count_in = poll_inc;
                        if (poll_inc >= token_poll_limit_ff) begin
                           phase_in                = PH_IDLE;
                           p1_in.res.select_active = 1'b0;
                           p1_in.res.done_res      = 1'b1;
                           p1_in.res.status        = ST_TOKEN_TIMEOUT;
                        end
                     end
                  end
                  PH_RDATA: begin
                     if (byte_count_ff < COUNT_W'(SECTOR_BYTES)) begin
                        ram_we                    = 1'b1;
                        ram_waddr                 = byte_count_ff[BUF_AW-1:0];
                        ram_wdata                 = req_miso_byte;
                        p1_in.res.read_byte       = req_miso_byte;
                        p1_in.res.read_byte_valid = 1'b1;
                     end
                     byte_count_in = byte_inc;
                     if (byte_inc >= COUNT_W'(SECTOR_BYTES + 2)) begin
                        phase_in                = PH_IDLE;
                        p1_in.res.select_active = 1'b0;
                        p1_in.res.done_res      = 1'b1;
                     end
                  end
                  PH_WTOKEN: begin
                     phase_in      = PH_WDATA;
                     byte_count_in = '0;
                     ram_re        = 1'b1;
                     ram_raddr     = '0;
                     p1_in.buf_sel = 1'b1;
                  end
                  PH_WDATA: begin
                     byte_count_in = byte_inc;
                     if (byte_inc < COUNT_W'(SECTOR_BYTES)) begin
                        ram_re        = 1'b1;
                        ram_raddr     = byte_inc[BUF_AW-1:0];
                        p1_in.buf_sel = 1'b1;
                     end else if (byte_inc >= COUNT_W'(SECTOR_BYTES + 2)) begin
                        phase_in = PH_WRESP;
                     end
                  end
                  PH_WRESP: begin
                     if ((req_miso_byte & DRESP_MASK) != DRESP_ACCEPTED) begin
                        phase_in                = PH_IDLE;
                        p1_in.res.select_active = 1'b0;
                        p1_in.res.done_res      = 1'b1;
                        p1_in.res.status        = ST_DRESP_ERROR;
                     end else begin
                        phase_in      = PH_BUSY;
                        poll_count_in = '0;
                     end
                  end
                  PH_BUSY: begin
                     if (req_miso_byte == IDLE_BYTE) begin
                        phase_in                = PH_IDLE;
                        p1_in.res.select_active = 1'b0;
                        p1_in.res.done_res      = 1'b1;
                     end else begin
                        poll_count_in = poll_inc;
                        if (poll_inc >= ready_poll_limit_ff) begin
                           phase_in                = PH_IDLE;
                           p1_in.res.select_active = 1'b0;
                           p1_in.res.done_res      = 1'b1;
                           p1_in.res.status        = ST_BUSY_TIMEOUT;
                        end
                     end
                  end
                  default: begin
                     phase_in                = PH_IDLE;
                     p1_in.res.select_active = 1'b0;
                  end
               endcase
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in = p1_ff.res;
      if (p1_ff.buf_sel) begin
         rsp_in.mosi_byte = ram_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_addressing_ff <= 1'b0;
         token_poll_limit_ff <= TOKEN_LIMIT_RESET;
         ready_poll_limit_ff <= READY_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_ADDRESSING: block_addressing_ff <= csr_wdata[0];
            CSR_TOKEN_POLL_LIMIT: token_poll_limit_ff <= csr_wdata;
            CSR_READY_POLL_LIMIT: ready_poll_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         op_is_write_ff  <= 1'b0;
         card_address_ff <= '0;
         byte_count_ff   <= '0;
         poll_count_ff   <= '0;
         p1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         op_is_write_ff  <= op_is_write_in;
         card_address_ff <= card_address_in;
         byte_count_ff   <= byte_count_in;
         poll_count_ff   <= poll_count_in;
         if (req_fire && res_valid) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_adv) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         p1_ff <= p1_in;
      end
      if (p1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   sdst_ram #(
      .WIDTH (8),
      .DEPTH (SECTOR_BYTES)
   ) u_sector_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mosi_byte       = rsp_ff.mosi_byte;
   assign rsp_select_active   = rsp_ff.select_active;
   assign rsp_read_byte       = rsp_ff.read_byte;
   assign rsp_read_byte_valid = rsp_ff.read_byte_valid;
   assign rsp_done_res        = rsp_ff.done_res;
   assign rsp_status          = rsp_ff.status;

   a_done_deselects: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.select_active)
      else $error("done transfer keeps card selected");

   a_error_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != ST_OK) |-> rsp_ff.done_res)
      else $error("nonzero status without done");

   a_read_byte_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_byte_valid |-> !rsp_ff.done_res && rsp_ff.select_active)
      else $error("read data byte on a closing result");

   a_buf_data_held: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && p1_ff.buf_sel && !p1_adv |=> p1_valid_ff && $stable(ram_rd_data))
      else $error("buffer read data lost while stage is stalled");

   a_one_ram_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("buffer written and read by one transfer");

endmodule
